>>> hw/rtl/dss_pkg.sv
// dss_pkg: constants, codes and types shared by the dual stack block.
// Used by every module of the block and by its checker; depends on nothing.
package dss_pkg;

   localparam int SIZE   = 64;
   localparam int HALF   = SIZE / 2;
   localparam int ADDR_W = $clog2(SIZE);
   localparam int CNT_W  = 7;
   localparam int SUM_W  = CNT_W + 1;

   typedef logic [1:0]        status_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [7:0]        byte_type;

   localparam status_type STS_OK        = 2'd0;
   localparam status_type STS_OVERFLOW  = 2'd1;
   localparam status_type STS_UNDERFLOW = 2'd2;

   localparam logic OP_POP  = 1'b0;
   localparam logic OP_PUSH = 1'b1;

   localparam logic SEL_FIRST  = 1'b0;
   localparam logic SEL_SECOND = 1'b1;

   localparam logic MODE_INTERLEAVED = 1'b0;
   localparam logic MODE_COLLIDING   = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

>>> hw/rtl/dss_if.sv
// dss_req_if / dss_rsp_if: valid/ready channels for operation and result words.
// Depends on dss_pkg for the payload types.
interface dss_req_if import dss_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     opcode;
   logic     stack_select;
   byte_type push_data;

   modport source (output valid, opcode, stack_select, push_data, input ready);
   modport sink   (input valid, opcode, stack_select, push_data, output ready);
endinterface

interface dss_rsp_if import dss_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   byte_type   pop_data;
   count_type  depth_first;
   count_type  depth_second;

   modport source (output valid, status, pop_data, depth_first, depth_second,
                   input ready);
   modport sink   (input valid, status, pop_data, depth_first, depth_second,
                   output ready);
endinterface

>>> hw/rtl/dual_stack_shared_memory.sv
// dual_stack_shared_memory: two byte stacks in one 64-entry memory.
// Depends on dss_pkg, dss_if, dss_ctrl and dss_dp.
//
// Usage:
//   req_bus carries one operation word: opcode (0 pop, 1 push), stack_select
//   and push_data. rsp_bus returns one result word per operation: status
//   (ok, overflow, underflow), pop_data and both stack depths after the
//   operation. csr_we/csr_wdata write the mode (0 interleaved even/odd
//   slots, 1 stacks growing toward each other); every write empties both
//   stacks. Write the mode only while no operation is outstanding.
//   Timing: a word is accepted in the idle state, the memory is read or
//   written in the next cycle, and the result is shown from the cycle
//   after that. One operation is in flight at a time: no new word is
//   accepted until the result has been taken.
//   A stalled result holds on rsp_bus until taken; req_ready stays low
//   meanwhile. Reset (synchronous, active high) empties both stacks,
//   selects interleaved mode and drops rsp valid; memory content is not
//   cleared and needs no clearing pass.
module dual_stack_shared_memory import dss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic      csr_wdata,
   dss_req_if.sink   req_bus,
   dss_rsp_if.source rsp_bus
);

   cmd_type cmd;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   dss_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .opcode       (req_bus.opcode),
      .stack_select (req_bus.stack_select),
      .push_data    (req_bus.push_data),
      .status       (rsp_bus.status),
      .pop_data     (rsp_bus.pop_data),
      .depth_first  (rsp_bus.depth_first),
      .depth_second (rsp_bus.depth_second)
   );

endmodule

>>> hw/rtl/dss_ctrl.sv
// dss_ctrl: sequencer for one word at a time: accept, execute, respond.
// Depends on dss_pkg for the command struct.
module dss_ctrl import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

>>> hw/rtl/dss_dp.sv
// dss_dp: shared stack memory, depth counters, mode register and result word.
// Depends on dss_pkg; driven by commands from dss_ctrl.
module dss_dp import dss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       opcode,
   input  logic       stack_select,
   input  byte_type   push_data,
   output status_type status,
   output byte_type   pop_data,
   output count_type  depth_first,
   output count_type  depth_second
);

   byte_type   mem [SIZE];

   logic       mode_ff;
   count_type  cnt_first_ff, cnt_first_in;
   count_type  cnt_second_ff, cnt_second_in;
   logic       op_ff;
   logic       sel_ff;
   byte_type   data_ff;
   status_type status_ff, status_in;
   logic       popok_ff;
   byte_type   rd_ff;

   count_type  cnt_sel;
   count_type  k;
   addr_type   slot;
   logic [SUM_W-1:0] sum;
   logic       full;
   logic       is_push;
   logic       wr_en;

   always_comb begin
      is_push = (op_ff == OP_PUSH);
      cnt_sel = (sel_ff == SEL_SECOND) ? cnt_second_ff : cnt_first_ff;
      sum     = SUM_W'(cnt_first_ff) + SUM_W'(cnt_second_ff);
      if (mode_ff == MODE_INTERLEAVED) begin
         full = (cnt_sel >= CNT_W'(HALF));
      end else begin
         full = (sum >= SUM_W'(SIZE));
      end
      k = is_push ? cnt_sel : cnt_sel - CNT_W'(1);
      if (mode_ff == MODE_INTERLEAVED) begin
         slot = ADDR_W'({k, sel_ff});
      end else if (sel_ff == SEL_SECOND) begin
         slot = ADDR_W'(CNT_W'(SIZE - 1) - k);
      end else begin
         slot = ADDR_W'(k);
      end
      if (is_push && full) begin
         status_in = STS_OVERFLOW;
      end else if (!is_push && (cnt_sel == '0)) begin
         status_in = STS_UNDERFLOW;
      end else begin
         status_in = STS_OK;
      end
      wr_en = cmd.exec && is_push && (status_in == STS_OK);

      cnt_first_in  = cnt_first_ff;
      cnt_second_in = cnt_second_ff;
      if (cmd.exec && (status_in == STS_OK)) begin
         if (sel_ff == SEL_SECOND) begin
            cnt_second_in = is_push ? cnt_second_ff + CNT_W'(1) : k;
         end else begin
            cnt_first_in = is_push ? cnt_first_ff + CNT_W'(1) : k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= data_ff;
      end
      if (cmd.exec) begin
         rd_ff     <= mem[slot];
         status_ff <= status_in;
      end
      if (cmd.load) begin
         op_ff   <= opcode;
         sel_ff  <= stack_select;
         data_ff <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_INTERLEAVED;
         cnt_first_ff  <= '0;
         cnt_second_ff <= '0;
         popok_ff      <= 1'b0;
      end else if (csr_we) begin
         mode_ff       <= csr_wdata;
         cnt_first_ff  <= '0;
         cnt_second_ff <= '0;
      end else begin
         cnt_first_ff  <= cnt_first_in;
         cnt_second_ff <= cnt_second_in;
         if (cmd.exec) begin
            popok_ff <= !is_push && (status_in == STS_OK);
         end
      end
   end

   assign status       = status_ff;
   assign pop_data     = popok_ff ? rd_ff : '0;
   assign depth_first  = cnt_first_ff;
   assign depth_second = cnt_second_ff;

endmodule

>>> hw/rtl/dss_chk.sv
// dss_chk: port-level checks on the dual stack block, bound to the top level.
// Depends on dss_pkg and dual_stack_shared_memory.
module dss_chk import dss_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input status_type status,
   input byte_type   pop_data,
   input count_type  depth_first,
   input count_type  depth_second
);

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((SUM_W'(depth_first) + SUM_W'(depth_second)) <= SUM_W'(SIZE)))
      else $error("combined depth exceeds memory size");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != STS_OK)) |-> (pop_data == '0))
      else $error("refused operation returned data");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready ##1 rsp_valid))
      else $error("word accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(pop_data)))
      else $error("stalled result word changed");

endmodule

bind dual_stack_shared_memory dss_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .pop_data     (rsp_bus.pop_data),
   .depth_first  (rsp_bus.depth_first),
   .depth_second (rsp_bus.depth_second)
);
